/* rtl/hns_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hns_pkg
// Shared types and constants of the heightfield normal stream unit.
// ----------------------------------------------------------------------------
package hns_pkg;

  localparam logic CFG_GRID_WIDTH = 1'b0;
  localparam logic CFG_GRID_DEPTH = 1'b1;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_DRAIN  = 1'b1;

  // vertical difference term, 2.0 in Q8.8
  localparam logic [9:0] UP_TERM = 10'd512;
  // component limit, 1.0 in Q1.14
  localparam logic [16:0] UNIT_Q14 = 17'd16384;

  typedef struct packed {
    logic signed [15:0] x;
    logic [14:0]        y;
    logic signed [15:0] z;
  } norm_res_t;

endpackage

/* rtl/hns_norm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hns_norm
// Multi-cycle unit normal: scale, square-sum, bitwise root, long division.
// ----------------------------------------------------------------------------
module hns_norm import hns_pkg::*; #(
  parameter int HeightBits = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [HeightBits-1:0] hl_i,
  input  logic signed [HeightBits-1:0] hr_i,
  input  logic signed [HeightBits-1:0] hd_i,
  input  logic signed [HeightBits-1:0] hu_i,
  output logic                         done_o,
  output norm_res_t                    res_o
);

  localparam int DW = HeightBits + 1;
  localparam int MW = (DW > 18) ? DW : 18;

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SQRT  = 3'd3;
  localparam logic [2:0] N_DINIT = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;
  localparam logic [2:0] N_DONE  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [MW-1:0] ax_q, ax_d, az_q, az_d;
  logic [9:0]    ay_q, ay_d;
  logic          negx_q, negx_d, negz_q, negz_d;
  logic [1:0]    comp_q, comp_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [35:0]   acc_q, acc_d;
  logic [63:0]   rad_q, rad_d;
  logic [34:0]   rem_q, rem_d;
  logic [31:0]   root_q, root_d;
  logic [31:0]   s_q, s_d;
  logic [31:0]   drem_q, drem_d;
  logic [16:0]   low_q, low_d;
  logic [16:0]   quo_q, quo_d;
  logic [14:0]   cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;

  logic signed [DW-1:0] dx, dz;
  logic [DW-1:0]        adx, adz;
  logic [16:0]          sq_op, div_m;
  logic [33:0]          sq_prod;
  logic [34:0]          sr_r, sr_t;
  logic [45:0]          num;
  logic [31:0]          s_eff;
  logic [32:0]          dv_r;
  logic [16:0]          q_nx, q_cl;

  always_comb begin
    dx  = DW'(hl_i) - DW'(hr_i);
    dz  = DW'(hd_i) - DW'(hu_i);
    adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
    adz = dz[DW-1] ? DW'(-dz) : DW'(dz);
  end

  always_comb begin
    case (comp_q)
      2'd0:    sq_op = ax_q[16:0];
      2'd1:    sq_op = 17'(ay_q);
      default: sq_op = az_q[16:0];
    endcase
    sq_prod = 34'(sq_op) * 34'(sq_op);
    sr_r = {rem_q[32:0], rad_q[63:62]};
    sr_t = {1'b0, root_q, 2'b01};
    s_eff = (root_q == '0) ? 32'd1 : root_q;
    case (comp_q)
      2'd0:    div_m = ax_q[16:0];
      2'd1:    div_m = 17'(ay_q);
      default: div_m = az_q[16:0];
    endcase
    num  = {1'b0, div_m, 28'd0} + 46'(s_eff >> 1);
    dv_r = {drem_q, low_q[16]};
    q_nx = (dv_r >= {1'b0, s_q}) ? {quo_q[15:0], 1'b1} : {quo_q[15:0], 1'b0};
    q_cl = (q_nx > UNIT_Q14) ? UNIT_Q14 : q_nx;
  end

  always_comb begin
    state_d = state_q;
    ax_d = ax_q; az_d = az_q; ay_d = ay_q;
    negx_d = negx_q; negz_d = negz_q;
    comp_d = comp_q; cnt_d = cnt_q; acc_d = acc_q;
    rad_d = rad_q; rem_d = rem_q; root_d = root_q;
    s_d = s_q; drem_d = drem_q; low_d = low_q; quo_d = quo_q;
    cx_d = cx_q; cy_d = cy_q; cz_d = cz_q;
    unique case (state_q)
      N_IDLE: begin
        if (start_i) begin
          ax_d    = MW'(adx);
          az_d    = MW'(adz);
          ay_d    = UP_TERM;
          negx_d  = dx[DW-1];
          negz_d  = dz[DW-1];
          state_d = N_SHIFT;
        end
      end
      N_SHIFT: begin
        if ((ax_q >> 17) != '0 || (az_q >> 17) != '0) begin
          ax_d = ax_q >> 1;
          az_d = az_q >> 1;
          ay_d = ay_q >> 1;
        end else begin
          comp_d  = 2'd0;
          acc_d   = '0;
          state_d = N_SQ;
        end
      end
      N_SQ: begin
        if (comp_q == 2'd3) begin
          rad_d   = {acc_q, 28'd0};
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = 5'd31;
          state_d = N_SQRT;
        end else begin
          acc_d  = acc_q + 36'(sq_prod);
          comp_d = comp_q + 2'd1;
        end
      end
      N_SQRT: begin
        if (sr_r >= sr_t) begin
          rem_d  = sr_r - sr_t;
          root_d = {root_q[30:0], 1'b1};
        end else begin
          rem_d  = sr_r;
          root_d = {root_q[30:0], 1'b0};
        end
        rad_d = rad_q << 2;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          comp_d  = 2'd0;
          state_d = N_DINIT;
        end
      end
      N_DINIT: begin
        s_d     = s_eff;
        drem_d  = 32'(num >> 17);
        low_d   = num[16:0];
        quo_d   = '0;
        cnt_d   = 5'd16;
        state_d = N_DIV;
      end
      N_DIV: begin
        drem_d = (dv_r >= {1'b0, s_q}) ? 32'(dv_r - {1'b0, s_q}) : dv_r[31:0];
        low_d  = low_q << 1;
        quo_d  = q_nx;
        cnt_d  = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          case (comp_q)
            2'd0:    cx_d = q_cl[14:0];
            2'd1:    cy_d = q_cl[14:0];
            default: cz_d = q_cl[14:0];
          endcase
          if (comp_q == 2'd2) begin
            state_d = N_DONE;
          end else begin
            comp_d  = comp_q + 2'd1;
            state_d = N_DINIT;
          end
        end
      end
      N_DONE:  state_d = N_IDLE;
      default: state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q <= ax_d; az_q <= az_d; ay_q <= ay_d;
    negx_q <= negx_d; negz_q <= negz_d;
    comp_q <= comp_d; cnt_q <= cnt_d; acc_q <= acc_d;
    rad_q <= rad_d; rem_q <= rem_d; root_q <= root_d;
    s_q <= s_d; drem_q <= drem_d; low_q <= low_d; quo_q <= quo_d;
    cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d;
  end

  assign done_o  = (state_q == N_DONE);
  assign res_o.x = negx_q ? -$signed({1'b0, cx_q}) : $signed({1'b0, cx_q});
  assign res_o.y = cy_q;
  assign res_o.z = negz_q ? -$signed({1'b0, cz_q}) : $signed({1'b0, cz_q});

endmodule

/* rtl/heightfield_normal_stream_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightfield_normal_stream_unit
// Central-difference unit normals over a raster stream of height samples.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes one sample or drain step per
// transfer. A sample of row r gives the normal of point (r-1, c); row 0 gives
// nothing. After the last row, grid_width drain steps flush the last row and
// the final one carries grid_done.
// Output channel (out_valid_o / out_stall_i) holds one result in a register;
// the next item is accepted while it waits to be taken.
// One item at a time: a dropped item leaves from S_IDLE, a row-0 sample goes
// through S_READ, and an item with a result also waits in S_NORM and S_OUT;
// the normal unit adds one step per halving of very wide differences, a
// bitwise square root (32 steps) and three 17-step divisions.
// Two line memories hold the previous and older rows; each item reads them
// once unless it is dropped, and the sample writes back in the following cycle.
// Reset clears counters and the output valid flag; line memories are not
// cleared. Config writes (cfg_valid_i / cfg_ready_o) are always taken.
// A stalled result is held and blocks the next result, not the next transfer.
// ----------------------------------------------------------------------------
module heightfield_normal_stream_unit import hns_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic signed [HEIGHT_BITS-1:0] height_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [15:0]            normal_x_o,
  output logic [14:0]                   normal_y_o,
  output logic signed [15:0]            normal_z_o,
  output logic [9:0]                    column_o,
  output logic [15:0]                   row_o,
  output logic                          grid_done_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int HB = HEIGHT_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_NORM = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [10:0]   gw_q;
  logic [15:0]   gd_q;
  logic [WW-1:0] col_q, col_d, drain_q, drain_d, c_q, c_d;
  logic [15:0]   row_q, row_d;
  logic          kind_q, kind_d;
  logic signed [HB-1:0] h_q, h_d, left_q, left_d;
  logic [9:0]    mcol_q, mcol_d;
  logic [15:0]   mrow_q, mrow_d;
  logic          mdone_q, mdone_d;
  logic          ovalid_q, ovalid_d;
  norm_res_t     ores_q, ores_d;
  logic [9:0]    ocol_q, ocol_d;
  logic [15:0]   orow_q, orow_d;
  logic          odone_q, odone_d;

  logic [WW-1:0] eff_w, wrap_col, k_col;
  logic [15:0]   eff_d, wrap_row;
  logic          in_acc, wrap, rd_en, wr_en, emit, last, slot_free;
  logic [AW-1:0] rd_a0, rd_a1;

  logic signed [HB-1:0] prev_mem [MAX_WIDTH];
  logic signed [HB-1:0] older_mem [MAX_WIDTH];
  logic signed [HB-1:0] pc_q, pn_q, od_q;
  logic signed [HB-1:0] center, hl, hr, hd, hu;

  logic      nstart, ndone;
  norm_res_t nres;

  always_comb begin
    if (gw_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(gw_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(gw_q);
    end
    eff_d = (gd_q == '0) ? 16'd1 : gd_q;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign slot_free   = !ovalid_q || !out_stall_i;

  always_comb begin
    wrap     = (col_q >= eff_w);
    wrap_row = wrap ? row_q + 16'd1 : row_q;
    wrap_col = wrap ? '0 : col_q;
    k_col    = (drain_q >= eff_w) ? eff_w - WW'(1) : drain_q;
  end

  always_comb begin
    center = pc_q;
    hl = (c_q != '0) ? left_q : center;
    hr = (({1'b0, c_q} + (WW+1)'(1)) < {1'b0, eff_w}) ? pn_q : center;
    if (kind_q == REQ_SAMPLE) begin
      hd = (row_q >= 16'd2) ? od_q : center;
      hu = h_q;
    end else begin
      hd = (eff_d >= 16'd2) ? od_q : center;
      hu = center;
    end
    last = (({1'b0, c_q} + (WW+1)'(1)) >= {1'b0, eff_w});
  end

  always_comb begin
    state_d = state_q;
    col_d = col_q; row_d = row_q; drain_d = drain_q;
    c_d = c_q; kind_d = kind_q; h_d = h_q; left_d = left_q;
    mcol_d = mcol_q; mrow_d = mrow_q; mdone_d = mdone_q;
    ovalid_d = ovalid_q; ores_d = ores_q;
    ocol_d = ocol_q; orow_d = orow_q; odone_d = odone_q;
    rd_en = 1'b0; wr_en = 1'b0; nstart = 1'b0; emit = 1'b0;
    rd_a0 = '0; rd_a1 = '0;

    if (ovalid_q && !out_stall_i) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          kind_d = req_type_i;
          h_d    = height_i;
          if (req_type_i == REQ_SAMPLE) begin
            if (row_q < eff_d) begin
              row_d = wrap_row;
              col_d = wrap_col;
              if (wrap_row < eff_d) begin
                c_d     = wrap_col;
                rd_en   = 1'b1;
                rd_a0   = AW'(wrap_col);
                rd_a1   = AW'(wrap_col + WW'(1));
                state_d = S_READ;
              end
            end
          end else if (row_q >= eff_d) begin
            c_d     = k_col;
            rd_en   = 1'b1;
            rd_a0   = AW'(k_col);
            rd_a1   = AW'(k_col + WW'(1));
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        left_d = center;
        mcol_d = 10'(32'(c_q));
        if (kind_q == REQ_SAMPLE) begin
          wr_en   = 1'b1;
          emit    = (row_q >= 16'd1);
          mrow_d  = row_q - 16'd1;
          mdone_d = 1'b0;
          if (last) begin
            col_d = '0;
            row_d = row_q + 16'd1;
          end else begin
            col_d = c_q + WW'(1);
          end
        end else begin
          emit    = 1'b1;
          mrow_d  = eff_d - 16'd1;
          mdone_d = last;
          if (last) begin
            row_d   = '0;
            col_d   = '0;
            drain_d = '0;
          end else begin
            drain_d = c_q + WW'(1);
          end
        end
        nstart  = emit;
        state_d = emit ? S_NORM : S_IDLE;
      end
      S_NORM: begin
        if (ndone) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          ores_d   = nres;
          ocol_d   = mcol_q;
          orow_d   = mrow_q;
          odone_d  = mdone_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      pc_q <= prev_mem[rd_a0];
      pn_q <= prev_mem[rd_a1];
      od_q <= older_mem[rd_a0];
    end
    if (wr_en) begin
      prev_mem[AW'(c_q)]  <= h_q;
      older_mem[AW'(c_q)] <= center;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      gw_q     <= 11'd256;
      gd_q     <= 16'd256;
      col_q    <= '0;
      row_q    <= '0;
      drain_q  <= '0;
      left_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      row_q    <= row_d;
      drain_q  <= drain_d;
      left_q   <= left_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_GRID_WIDTH: gw_q <= cfg_data_i[10:0];
          CFG_GRID_DEPTH: gd_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d; kind_q <= kind_d; h_q <= h_d;
    mcol_q <= mcol_d; mrow_q <= mrow_d; mdone_q <= mdone_d;
    ores_q <= ores_d; ocol_q <= ocol_d; orow_q <= orow_d; odone_q <= odone_d;
  end

  hns_norm #(
    .HeightBits(HB)
  ) u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(nstart),
    .hl_i   (hl),
    .hr_i   (hr),
    .hd_i   (hd),
    .hu_i   (hu),
    .done_o (ndone),
    .res_o  (nres)
  );

  assign out_valid_o = ovalid_q;
  assign normal_x_o  = ores_q.x;
  assign normal_y_o  = ores_q.y;
  assign normal_z_o  = ores_q.z;
  assign column_o    = ocol_q;
  assign row_o       = orow_q;
  assign grid_done_o = odone_q;

endmodule

/* dv/heightfield_normal_stream_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightfield_normal_stream_unit_test
// Streams whole height grids (samples, then drain steps) through the unit under
// several grid sizes and idle/stall patterns. A scoreboard tracks the line
// buffers and counters, predicts each normal and compares every transfer.
// ----------------------------------------------------------------------------
module heightfield_normal_stream_unit_test;
  import hns_pkg::*;

  localparam int MAX_W     = 1024;
  localparam int CYC_LIMIT = 3000000;
  localparam int SETTLE    = 120;

  typedef struct packed {
    logic [15:0] x;
    logic [14:0] y;
    logic [15:0] z;
    logic [9:0]  col;
    logic [15:0] row;
    logic        done;
  } normal_t;

  class normal_scoreboard;
    int unsigned width_reg = 256;
    int unsigned depth_reg = 256;
    longint      older_row[MAX_W];
    longint      prev_row[MAX_W];
    longint      left_h;
    int unsigned col_cnt, row_cnt, drain_col;
    normal_t     expq[$];
    int          errors;

    function int unsigned eff_w();
      if (width_reg < 1) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function int unsigned eff_d();
      return (depth_reg < 1) ? 1 : depth_reg;
    endfunction

    function void set_reg(logic idx, logic [15:0] data);
      if (idx == CFG_GRID_WIDTH) width_reg = data[10:0];
      else depth_reg = data;
    endfunction

    function bit [63:0] root64(bit [63:0] v);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function bit [63:0] unit_scale(bit [63:0] m, bit [63:0] s);
      bit [63:0] q;
      q = ((m << 28) + (s >> 1)) / s;
      return (q > 16384) ? 64'd16384 : q;
    endfunction

    function normal_t surface_normal(longint hl, longint hr, longint hd, longint hu);
      longint    dx, dz;
      bit [63:0] ax, az, ay, s, cx, cz;
      normal_t   n;
      dx = hl - hr;
      dz = hd - hu;
      ax = (dx < 0) ? -dx : dx;
      az = (dz < 0) ? -dz : dz;
      ay = 512;
      while (ax >= (64'd1 << 17) || az >= (64'd1 << 17)) begin
        ax >>= 1;
        az >>= 1;
        ay >>= 1;
      end
      s = root64((ax * ax + ay * ay + az * az) << 28);
      if (s == 0) s = 1;
      cx = unit_scale(ax, s);
      cz = unit_scale(az, s);
      n.x = (dx < 0) ? 16'(-cx) : 16'(cx);
      n.y = 15'(unit_scale(ay, s));
      n.z = (dz < 0) ? 16'(-cz) : 16'(cz);
      return n;
    endfunction

    function void note(logic rt, logic signed [15:0] h);
      int unsigned w, d, c, k;
      longint      ctr, hl, hr, hd;
      normal_t     n;
      w = eff_w();
      d = eff_d();
      if (rt == REQ_SAMPLE) begin
        if (row_cnt >= d) return;
        if (col_cnt >= w) begin
          col_cnt = 0;
          row_cnt++;
          if (row_cnt >= d) return;
        end
        c = col_cnt;
        ctr = prev_row[c];
        if (row_cnt >= 1) begin
          hl = (c > 0) ? left_h : ctr;
          hr = (c + 1 < w) ? prev_row[c + 1] : ctr;
          hd = (row_cnt >= 2) ? older_row[c] : ctr;
          n = surface_normal(hl, hr, hd, longint'(h));
          n.col = c[9:0];
          n.row = 16'(row_cnt - 1);
          n.done = 1'b0;
          expq = {expq, n};
        end
        older_row[c] = ctr;
        prev_row[c] = h;
        left_h = ctr;
        col_cnt = c + 1;
        if (col_cnt >= w) begin
          col_cnt = 0;
          row_cnt++;
        end
      end else begin
        if (row_cnt < d) return;
        k = (drain_col >= w) ? w - 1 : drain_col;
        ctr = prev_row[k];
        hl = (k > 0) ? left_h : ctr;
        hr = (k + 1 < w) ? prev_row[k + 1] : ctr;
        hd = (d >= 2) ? older_row[k] : ctr;
        n = surface_normal(hl, hr, hd, ctr);
        n.col = k[9:0];
        n.row = 16'(d - 1);
        n.done = (k + 1 >= w);
        expq = {expq, n};
        left_h = ctr;
        if (n.done) begin
          row_cnt = 0;
          col_cnt = 0;
          drain_col = 0;
        end else begin
          drain_col = k + 1;
        end
      end
    endfunction

    function void check(normal_t got);
      normal_t e;
      if (expq.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transfer col %0d row %0d", got.col, got.row);
        return;
      end
      e = expq.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp x %h y %h z %h c %0d r %0d d %b, got x %h y %h z %h c %0d r %0d d %b",
                   e.x, e.y, e.z, e.col, e.row, e.done,
                   got.x, got.y, got.z, got.col, got.row, got.done);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               req_type_i = REQ_SAMPLE;
  logic signed [15:0] height_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] normal_x_o;
  logic [14:0]        normal_y_o;
  logic signed [15:0] normal_z_o;
  logic [9:0]         column_o;
  logic [15:0]        row_o;
  logic               grid_done_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i = CFG_GRID_WIDTH;
  logic [15:0]        cfg_data_i = '0;

  normal_scoreboard sb = new();
  int               idle_pct = 0;
  int               stall_pct = 0;
  int               items_sent = 0;
  int               cycles = 0;

  heightfield_normal_stream_unit dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) out_stall_i = ($urandom % 100) < stall_pct;

  always @(posedge clk_i) begin
    normal_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.x = normal_x_o;
      got.y = normal_y_o;
      got.z = normal_z_o;
      got.col = column_o;
      got.row = row_o;
      got.done = grid_done_o;
      sb.check(got);
    end
  end

  task automatic push_item(logic rt, logic [15:0] h);
    @(negedge clk_i);
    while (($urandom % 100) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    req_type_i = rt;
    height_i = h;
    do @(posedge clk_i); while (in_stall_o);
    sb.note(rt, h);
    items_sent++;
  endtask

  task automatic drain_out();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.expq.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_phase(int p);
    case (p % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 58; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 58; end
      default: begin idle_pct = 19; stall_pct = 19; end
    endcase
  endtask

  function automatic logic [15:0] pick_height(int mode, logic [15:0] base);
    if (mode == 0) return 16'($urandom);
    return base + 16'($urandom_range(0, 128)) - 16'd64;
  endfunction

  task automatic run_grid(logic [15:0] wv, logic [15:0] dv, bit directed);
    int unsigned w, d;
    int          mode;
    logic [15:0] base, h;
    drain_out();
    write_reg(CFG_GRID_WIDTH, wv);
    write_reg(CFG_GRID_DEPTH, dv);
    w = sb.eff_w();
    d = sb.eff_d();
    mode = $urandom_range(0, 2);
    base = 16'($urandom);
    for (int r = 0; r < d; r++) begin
      for (int c = 0; c < w; c++) begin
        if (($urandom % 100) < 4) push_item(REQ_DRAIN, 16'($urandom));
        if (directed) h = ((r + c) % 2) ? 16'h8000 : 16'h7fff;
        else h = pick_height(mode, base);
        push_item(REQ_SAMPLE, h);
        if (mode != 0) base = h;
      end
    end
    if (directed || ($urandom % 100) < 30)
      repeat ($urandom_range(1, 3)) push_item(REQ_SAMPLE, 16'($urandom));
    for (int k = 0; k < w; k++) push_item(REQ_DRAIN, 16'($urandom));
  endtask

  initial begin
    int g;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_phase(0);
    run_grid(16'd3, 16'd3, 1'b1);
    set_phase(1);
    run_grid(16'd0, 16'd0, 1'b0);
    set_phase(2);
    run_grid(16'd2, 16'd1, 1'b1);
    drain_out();
    write_reg(CFG_GRID_DEPTH, 16'hffff);
    set_phase(0);
    run_grid(16'h07ff, 16'd1, 1'b0);

    g = 0;
    while (g < 4 || items_sent < 2200) begin
      set_phase(g);
      if (($urandom % 100) < 8)
        run_grid(16'($urandom_range(20, 64)), 16'($urandom_range(1, 3)), 1'b0);
      else
        run_grid(16'($urandom_range(1, 12)), 16'($urandom_range(1, 6)), 1'b0);
      g++;
    end

    drain_out();
    if (sb.errors == 0 && sb.expq.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
